// ===== rtl/core/i2c_register_master_macros.svh =====
// Assertion macros for the I2C register master.
// Included by the top level; define ASSERT_OFF to compile the checks out.
`ifndef I2C_REGISTER_MASTER_MACROS_SVH
`define I2C_REGISTER_MASTER_MACROS_SVH

`ifndef ASSERT_OFF

`define I2CRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c_register_master: same-cycle check failed");

`define I2CRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c_register_master: next-cycle check failed");

`else

`define I2CRM_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define I2CRM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/i2crm_pkg.sv =====
// Types and constants of the I2C register master.
// Used by i2crm_step and i2c_register_master; depends on nothing.
package i2crm_pkg;

    // phase codes
    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST_A = 5'd1;
    localparam logic [4:0] PH_ST_B = 5'd2;
    localparam logic [4:0] PH_ST_C = 5'd3;
    localparam logic [4:0] PH_BYTE = 5'd4;
    localparam logic [4:0] PH_RS_A = 5'd20;
    localparam logic [4:0] PH_RS_B = 5'd21;
    localparam logic [4:0] PH_RS_C = 5'd22;
    localparam logic [4:0] PH_RS_D = 5'd23;
    localparam logic [4:0] PH_RXL  = 5'd24;
    localparam logic [4:0] PH_RXH  = 5'd25;
    localparam logic [4:0] PH_MKL  = 5'd26;
    localparam logic [4:0] PH_MKH  = 5'd27;
    localparam logic [4:0] PH_SP_A = 5'd28;
    localparam logic [4:0] PH_SP_B = 5'd29;
    localparam logic [4:0] PH_SP_C = 5'd30;

    // byte kinds inside the byte phase block
    localparam logic [1:0] KIND_ADW = 2'd0;
    localparam logic [1:0] KIND_REG = 2'd1;
    localparam logic [1:0] KIND_ADR = 2'd2;
    localparam logic [1:0] KIND_DAT = 2'd3;

    // commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_PHASE_TICKS    = 2'd1;

    localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd104;
    localparam logic [15:0] PHASE_TICKS_RESET    = 16'd1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] reg_addr;
        logic [7:0] write_byte;
        logic [6:0] byte_count;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       nack_seen;
        logic       busy_res;
        logic       done_res;
    } rsp_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] reg_addr;
        logic [7:0] data;
    } saved_t;

    typedef struct packed {
        logic [4:0]  phase;
        logic [2:0]  bit_index;
        logic [7:0]  shift;
        logic [6:0]  bytes_left;
        logic [15:0] tick_count;
        saved_t      saved;
    } state_t;

endpackage

// ===== rtl/core/i2crm_step.sv =====
// Next-state and result logic of the I2C register master for one tick item.
// Depends on i2crm_pkg; purely combinational.
module i2crm_step #(
    parameter int MAX_BURST = 64
) (
    input  i2crm_pkg::state_t st,
    input  i2crm_pkg::req_t   item,
    input  logic [6:0]        dev_addr,
    input  logic [15:0]       phase_ticks,
    output i2crm_pkg::state_t st_next,
    output i2crm_pkg::rsp_t   rsp
);

    always_comb
    begin
        logic [15:0] pt;
        logic [16:0] tick_inc;
        logic [6:0]  n;
        logic [1:0]  lv;
        logic [1:0]  kind;
        logic        load_byte;
        logic [1:0]  load_kind;
        logic [7:0]  rx_shift;
        logic        last_byte;

        st_next   = st;
        rsp       = '0;
        lv        = 2'b11;
        load_byte = 1'b0;
        load_kind = i2crm_pkg::KIND_ADW;
        pt        = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
        tick_inc  = {1'b0, st.tick_count} + 17'd1;
        kind      = 2'(st.phase[4:2] - 3'd1);
        rx_shift  = {st.shift[6:0], item.sda_in};
        last_byte = (st.bytes_left <= 7'd1);

        n = item.byte_count;
        if (n == 7'd0)
        begin
            n = 7'd1;
        end
        if ({1'b0, n} > 8'(MAX_BURST))
        begin
            n = 7'(MAX_BURST);
        end

        if (st.phase == i2crm_pkg::PH_IDLE || st.phase > i2crm_pkg::PH_SP_C)
        begin
            st_next.phase      = i2crm_pkg::PH_IDLE;
            st_next.tick_count = '0;
            if (item.cmd == i2crm_pkg::CMD_READ || item.cmd == i2crm_pkg::CMD_WRITE)
            begin
                st_next.bytes_left     = n;
                st_next.saved.cmd      = item.cmd;
                st_next.saved.reg_addr = item.reg_addr;
                st_next.saved.data     = item.write_byte;
                st_next.phase          = i2crm_pkg::PH_ST_A;
            end
        end
        else
        begin
            // line levels of the current phase
            if (st.phase >= i2crm_pkg::PH_BYTE && st.phase < i2crm_pkg::PH_RS_A)
            begin
                case (st.phase[1:0])
                    2'd0:    lv = {1'b0, st.shift[7]};
                    2'd1:    lv = {1'b1, st.shift[7]};
                    2'd2:    lv = 2'b01;
                    default: lv = 2'b11;
                endcase
            end
            else
            begin
                unique case (st.phase)
                    i2crm_pkg::PH_ST_A: lv = 2'b11;
                    i2crm_pkg::PH_ST_B: lv = 2'b10;
                    i2crm_pkg::PH_ST_C: lv = 2'b00;
                    i2crm_pkg::PH_RS_A: lv = 2'b01;
                    i2crm_pkg::PH_RS_B: lv = 2'b11;
                    i2crm_pkg::PH_RS_C: lv = 2'b10;
                    i2crm_pkg::PH_RS_D: lv = 2'b00;
                    i2crm_pkg::PH_RXL:  lv = 2'b01;
                    i2crm_pkg::PH_RXH:  lv = 2'b11;
                    i2crm_pkg::PH_MKL:  lv = last_byte ? 2'b01 : 2'b00;
                    i2crm_pkg::PH_MKH:  lv = last_byte ? 2'b11 : 2'b10;
                    i2crm_pkg::PH_SP_A: lv = 2'b00;
                    i2crm_pkg::PH_SP_B: lv = 2'b10;
                    default:            lv = 2'b11;
                endcase
            end

            if (tick_inc < {1'b0, pt})
            begin
                st_next.tick_count = tick_inc[15:0];
            end
            else
            begin
                // last tick of the phase: sample and advance
                st_next.tick_count = '0;
                if (st.phase >= i2crm_pkg::PH_BYTE && st.phase < i2crm_pkg::PH_RS_A)
                begin
                    case (st.phase[1:0])
                        2'd0, 2'd2:
                        begin
                            st_next.phase = st.phase + 5'd1;
                        end
                        2'd1:
                        begin
                            if (st.bit_index == 3'd7)
                            begin
                                st_next.phase = st.phase + 5'd1;
                            end
                            else
                            begin
                                st_next.bit_index = st.bit_index + 3'd1;
                                st_next.shift     = {st.shift[6:0], 1'b0};
                                st_next.phase     = st.phase - 5'd1;
                            end
                        end
                        default:
                        begin
                            rsp.nack_seen = item.sda_in;
                            case (kind)
                                i2crm_pkg::KIND_ADW:
                                begin
                                    load_byte = 1'b1;
                                    load_kind = i2crm_pkg::KIND_REG;
                                end
                                i2crm_pkg::KIND_REG:
                                begin
                                    if (st.saved.cmd == i2crm_pkg::CMD_READ)
                                    begin
                                        st_next.phase = i2crm_pkg::PH_RS_A;
                                    end
                                    else
                                    begin
                                        load_byte = 1'b1;
                                        load_kind = i2crm_pkg::KIND_DAT;
                                    end
                                end
                                i2crm_pkg::KIND_ADR:
                                begin
                                    st_next.shift     = '0;
                                    st_next.bit_index = '0;
                                    st_next.phase     = i2crm_pkg::PH_RXL;
                                end
                                default:
                                begin
                                    st_next.phase = i2crm_pkg::PH_SP_A;
                                end
                            endcase
                        end
                    endcase
                end
                else
                begin
                    unique case (st.phase)
                        i2crm_pkg::PH_ST_A, i2crm_pkg::PH_ST_B, i2crm_pkg::PH_RS_A,
                        i2crm_pkg::PH_RS_B, i2crm_pkg::PH_RS_C, i2crm_pkg::PH_RXL,
                        i2crm_pkg::PH_MKL, i2crm_pkg::PH_SP_A, i2crm_pkg::PH_SP_B:
                        begin
                            st_next.phase = st.phase + 5'd1;
                        end
                        i2crm_pkg::PH_ST_C:
                        begin
                            load_byte = 1'b1;
                            load_kind = i2crm_pkg::KIND_ADW;
                        end
                        i2crm_pkg::PH_RS_D:
                        begin
                            load_byte = 1'b1;
                            load_kind = i2crm_pkg::KIND_ADR;
                        end
                        i2crm_pkg::PH_RXH:
                        begin
                            st_next.shift = rx_shift;
                            if (st.bit_index == 3'd7)
                            begin
                                rsp.rx_valid  = 1'b1;
                                rsp.rx_byte   = rx_shift;
                                rsp.rx_last   = last_byte;
                                st_next.phase = i2crm_pkg::PH_MKL;
                            end
                            else
                            begin
                                st_next.bit_index = st.bit_index + 3'd1;
                                st_next.phase     = i2crm_pkg::PH_RXL;
                            end
                        end
                        i2crm_pkg::PH_MKH:
                        begin
                            if (last_byte)
                            begin
                                st_next.phase = i2crm_pkg::PH_SP_A;
                            end
                            else
                            begin
                                st_next.bytes_left = st.bytes_left - 7'd1;
                                st_next.shift      = '0;
                                st_next.bit_index  = '0;
                                st_next.phase      = i2crm_pkg::PH_RXL;
                            end
                        end
                        i2crm_pkg::PH_SP_C:
                        begin
                            rsp.done_res  = 1'b1;
                            st_next.phase = i2crm_pkg::PH_IDLE;
                        end
                        default:
                        begin
                            st_next.phase = i2crm_pkg::PH_IDLE;
                        end
                    endcase
                end

                if (load_byte)
                begin
                    case (load_kind)
                        i2crm_pkg::KIND_ADW: st_next.shift = {dev_addr, 1'b0};
                        i2crm_pkg::KIND_REG: st_next.shift = st.saved.reg_addr;
                        i2crm_pkg::KIND_ADR: st_next.shift = {dev_addr, 1'b1};
                        default:             st_next.shift = st.saved.data;
                    endcase
                    st_next.bit_index = '0;
                    st_next.phase     = i2crm_pkg::PH_BYTE + {1'b0, load_kind, 2'b00};
                end
            end
        end

        rsp.scl_out  = lv[1];
        rsp.sda_out  = lv[0];
        rsp.busy_res = (st_next.phase != i2crm_pkg::PH_IDLE);
    end

endmodule

// ===== rtl/core/i2c_register_master.sv =====
// Top level of the I2C register master: state, configuration and result registers.
// Depends on i2crm_pkg, i2crm_step and i2c_register_master_macros.svh.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   req      | req_valid/req_stall  | req_item  (i2crm_pkg::req_t)
//   rsp      | rsp_valid/rsp_stall  | rsp_item  (i2crm_pkg::rsp_t)
//   cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Each accepted tick item yields exactly one result item in the cycle after; while
// rsp_stall is low, one item per cycle is sustained, set by the single result register
// after the phase logic. Reset puts the bus sequencer in idle with both lines released,
// device address 104, one tick per phase. When the result register is full and
// rsp_stall is high, req_stall rises and the sequencer holds. cfg_ready is always high.
`include "i2c_register_master_macros.svh"

module i2c_register_master #(
    parameter int MAX_BURST = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  i2crm_pkg::req_t   req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output i2crm_pkg::rsp_t   rsp_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    i2crm_pkg::state_t st_reg;
    i2crm_pkg::state_t st_next;
    i2crm_pkg::rsp_t   rsp_comb;
    i2crm_pkg::rsp_t   rsp_item_reg;
    logic              rsp_valid_reg;
    logic [6:0]        dev_addr_reg;
    logic [15:0]       phase_ticks_reg;
    logic              accept;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    i2crm_step #(
        .MAX_BURST (MAX_BURST)
    ) u_step (
        .st          (st_reg),
        .item        (req_item),
        .dev_addr    (dev_addr_reg),
        .phase_ticks (phase_ticks_reg),
        .st_next     (st_next),
        .rsp         (rsp_comb)
    );

    // an all-zero state is idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= '0;
            rsp_valid_reg   <= 1'b0;
            dev_addr_reg    <= i2crm_pkg::DEVICE_ADDRESS_RESET;
            phase_ticks_reg <= i2crm_pkg::PHASE_TICKS_RESET;
        end
        else
        begin
            if (accept)
            begin
                st_reg        <= st_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    i2crm_pkg::CFG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_data[6:0];
                    i2crm_pkg::CFG_PHASE_TICKS:    phase_ticks_reg <= cfg_data;
                    default:                       ;
                endcase
            end
        end
    end

    // result payload: load on accept only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_item_reg <= rsp_comb;
        end
    end

    // a received byte is sampled with SCL high
    `I2CRM_ASSERT_IMP(a_rx_scl_high, clk, rst_n, rsp_valid && rsp_item.rx_valid, rsp_item.scl_out && !rsp_item.sda_out || rsp_item.scl_out)

    // stop completes with both lines released and the block idle
    `I2CRM_ASSERT_IMP(a_done_idle, clk, rst_n, rsp_valid && rsp_item.done_res, rsp_item.scl_out && rsp_item.sda_out && !rsp_item.busy_res)

    // receive phases always have at least one byte left
    `I2CRM_ASSERT_IMP(a_rx_count, clk, rst_n, st_reg.phase == i2crm_pkg::PH_RXL || st_reg.phase == i2crm_pkg::PH_RXH || st_reg.phase == i2crm_pkg::PH_MKL || st_reg.phase == i2crm_pkg::PH_MKH, st_reg.bytes_left != 7'd0)

    // an accepted item always shows up as a result next cycle
    `I2CRM_ASSERT_NXT(a_accept_rsp, clk, rst_n, accept, rsp_valid_reg && st_reg == $past(st_next))

endmodule

// ===== sim/tb_i2c_register_master.sv =====
// Testbench for i2c_register_master: drives tick items, predicts the bus view per tick.
// Depends on i2crm_pkg and the i2c_register_master RTL; needs no files or arguments.
// Directed register reads and writes come first, then random transactions over settings.
module tb_i2c_register_master;
    timeunit 1ns;
    timeprecision 1ps;

    import i2crm_pkg::*;

    localparam int BURST_CAP   = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 16;
    localparam int RUN_BUDGET  = 30;
    localparam int LONG_RUN    = 40;
    localparam int PLAN_ROWS   = 14;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // released lines, nothing reported; with and without a transaction in flight
    localparam rsp_t IDLE_BUS = {1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam rsp_t BUSY_BUS = {1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0};

    typedef enum logic [1:0] {SDA_ACK, SDA_NACK, SDA_RANDOM} sda_mode_e;

    typedef struct packed {
        req_t      item;
        logic      run_out;
        sda_mode_e mode;
        logic      typed;
        rsp_t      want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req_item = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_DEVICE_ADDRESS;
    logic [15:0] cfg_data = '0;

    // predicted bus state and settings
    logic [4:0]  ph;
    logic [2:0]  bidx;
    logic [7:0]  shreg;
    logic [6:0]  bytes_due;
    logic [15:0] tcount;
    saved_t      saved;
    logic [6:0]  dev_addr;
    logic [15:0] pticks;

    rsp_t      predicted_bus[$];
    plan_row_t plan [PLAN_ROWS];
    logic      steady = 1'b0;
    int        errors = 0;
    int        quiet = 0;
    int        n_ticks = 0;
    int        n_reads = 0;
    int        n_writes = 0;
    int        n_rx_bytes = 0;
    int        n_stops = 0;
    int        n_settings = 0;

    i2c_register_master #(
        .MAX_BURST(BURST_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_item(req_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item(rsp_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void load_byte(input logic [1:0] kind);
        logic [7:0] dev;
        dev = {dev_addr, 1'b0};
        case (kind)
            KIND_ADW: shreg = dev;
            KIND_REG: shreg = saved.reg_addr;
            KIND_ADR: shreg = dev | 8'h01;
            default: shreg = saved.data;
        endcase
        bidx = '0;
        ph = PH_BYTE + {1'b0, kind, 2'b00};
    endfunction

    // Advance the predicted sequencer by one tick and return what the bus shows.
    function automatic rsp_t bus_tick(input req_t t);
        rsp_t        r;
        logic [1:0]  lines;
        logic [15:0] span;
        logic [6:0]  n;
        logic [4:0]  off;
        r = '0;
        span = (pticks == 16'd0) ? 16'd1 : pticks;
        if (ph == PH_IDLE || ph > PH_SP_C)
        begin
            lines = 2'b11;
            ph = PH_IDLE;
            tcount = '0;
            if (t.cmd == CMD_READ || t.cmd == CMD_WRITE)
            begin
                n = (t.byte_count == 7'd0) ? 7'd1 : t.byte_count;
                bytes_due = (n > BURST_CAP) ? 7'(BURST_CAP) : n;
                saved = {t.cmd, t.reg_addr, t.write_byte};
                ph = PH_ST_A;
                if (t.cmd == CMD_READ)
                    n_reads++;
                else
                    n_writes++;
            end
        end
        else
        begin
            off = ph - PH_BYTE;
            if (ph >= PH_BYTE && ph < PH_RS_A)
            begin
                case (off[1:0])
                    2'd0: lines = {1'b0, shreg[7]};
                    2'd1: lines = {1'b1, shreg[7]};
                    2'd2: lines = 2'b01;
                    default: lines = 2'b11;
                endcase
            end
            else
            begin
                case (ph)
                    PH_ST_A, PH_RS_B, PH_RXH, PH_SP_C: lines = 2'b11;
                    PH_ST_B, PH_RS_C, PH_SP_B: lines = 2'b10;
                    PH_ST_C, PH_RS_D, PH_SP_A: lines = 2'b00;
                    PH_RS_A, PH_RXL: lines = 2'b01;
                    PH_MKL: lines = (bytes_due <= 7'd1) ? 2'b01 : 2'b00;
                    PH_MKH: lines = (bytes_due <= 7'd1) ? 2'b11 : 2'b10;
                    default: lines = 2'b11;
                endcase
            end
            tcount = tcount + 16'd1;
            // sample and advance on the last tick of the phase
            if (tcount >= span)
            begin
                tcount = '0;
                if (ph >= PH_BYTE && ph < PH_RS_A)
                begin
                    case (off[1:0])
                        2'd0, 2'd2: ph = ph + 5'd1;
                        2'd1:
                        begin
                            if (bidx == 3'd7)
                                ph = ph + 5'd1;
                            else
                            begin
                                bidx = bidx + 3'd1;
                                shreg = shreg << 1;
                                ph = ph - 5'd1;
                            end
                        end
                        default:
                        begin
                            r.nack_seen = t.sda_in;
                            case (off[3:2])
                                KIND_ADW: load_byte(KIND_REG);
                                KIND_REG:
                                begin
                                    if (saved.cmd == CMD_READ)
                                        ph = PH_RS_A;
                                    else
                                        load_byte(KIND_DAT);
                                end
                                KIND_ADR:
                                begin
                                    shreg = '0;
                                    bidx = '0;
                                    ph = PH_RXL;
                                end
                                default: ph = PH_SP_A;
                            endcase
                        end
                    endcase
                end
                else
                begin
                    case (ph)
                        PH_ST_A, PH_ST_B, PH_RS_A, PH_RS_B, PH_RS_C,
                        PH_RXL, PH_MKL, PH_SP_A, PH_SP_B: ph = ph + 5'd1;
                        PH_ST_C: load_byte(KIND_ADW);
                        PH_RS_D: load_byte(KIND_ADR);
                        PH_RXH:
                        begin
                            shreg = {shreg[6:0], t.sda_in};
                            if (bidx == 3'd7)
                            begin
                                r.rx_valid = 1'b1;
                                r.rx_byte = shreg;
                                r.rx_last = (bytes_due <= 7'd1);
                                ph = PH_MKL;
                            end
                            else
                            begin
                                bidx = bidx + 3'd1;
                                ph = PH_RXL;
                            end
                        end
                        PH_MKH:
                        begin
                            if (bytes_due <= 7'd1)
                                ph = PH_SP_A;
                            else
                            begin
                                bytes_due = bytes_due - 7'd1;
                                shreg = '0;
                                bidx = '0;
                                ph = PH_RXL;
                            end
                        end
                        PH_SP_C:
                        begin
                            r.done_res = 1'b1;
                            ph = PH_IDLE;
                        end
                        default: ph = PH_IDLE;
                    endcase
                end
            end
        end
        r.scl_out = lines[1];
        r.sda_out = lines[0];
        r.busy_res = (ph != PH_IDLE);
        return r;
    endfunction

    function automatic req_t random_tick(input sda_mode_e mode);
        req_t t;
        t.cmd = 2'($urandom_range(3));
        t.reg_addr = 8'($urandom_range(255));
        t.write_byte = 8'($urandom_range(255));
        t.byte_count = 7'($urandom_range(127));
        case (mode)
            SDA_ACK: t.sda_in = 1'b0;
            SDA_NACK: t.sda_in = 1'b1;
            default: t.sda_in = 1'($urandom_range(1));
        endcase
        return t;
    endfunction

    function automatic plan_row_t mk_row(input logic [1:0] cmd, input logic [7:0] ra,
                                         input logic [7:0] wb, input logic [6:0] bc,
                                         input logic sda, input logic run_out,
                                         input sda_mode_e mode, input logic typed,
                                         input rsp_t want);
        plan_row_t row;
        row.item = {cmd, ra, wb, bc, sda};
        row.run_out = run_out;
        row.mode = mode;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    // Present one tick item, hold it until taken, then record its prediction.
    task automatic send_tick(input req_t t, input logic typed, input rsp_t want);
        rsp_t pred;
        while (!steady && $urandom_range(99) < 13)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item <= t;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pred = bus_tick(t);
        predicted_bus.push_back(typed ? want : pred);
        n_ticks++;
    endtask

    // Tick until the predicted transaction is over; commands inside are ignored.
    task automatic run_out(input sda_mode_e mode);
        while (ph != PH_IDLE)
            send_tick(random_tick(mode), 1'b0, IDLE_BUS);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (predicted_bus.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [6:0] dev, input logic [15:0] pt);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEVICE_ADDRESS;
        cfg_data <= {9'd0, dev};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        dev_addr = dev;
        cfg_index <= CFG_PHASE_TICKS;
        cfg_data <= pt;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        pticks = pt;
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(input int budget);
        int        stop;
        int        roll;
        int        pick;
        req_t      t;
        sda_mode_e mode;
        stop = n_ticks + budget;
        while (n_ticks < stop)
        begin
            roll = $urandom_range(99);
            t = random_tick(SDA_RANDOM);
            if (roll < 15)
            begin
                // noise between transactions
                t.cmd = (roll < 5) ? CMD_UNKNOWN : CMD_NONE;
                send_tick(t, 1'b0, IDLE_BUS);
            end
            else
            begin
                t.cmd = (roll < 55) ? CMD_READ : CMD_WRITE;
                pick = $urandom_range(99);
                // short bursts keep the item count down; the full burst is directed
                if (pick < 70)
                    t.byte_count = 7'($urandom_range(4, 1));
                else if (pick < 95)
                    t.byte_count = 7'($urandom_range(8, 0));
                else
                    t.byte_count = 7'($urandom_range(16, 9));
                pick = $urandom_range(99);
                mode = (pick < 70) ? SDA_RANDOM : (pick < 90) ? SDA_ACK : SDA_NACK;
                send_tick(t, 1'b0, IDLE_BUS);
                run_out(mode);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
        rsp_stall <= !steady && ($urandom_range(99) < 13);

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (predicted_bus.size() == 0)
            begin
                $error("result item with nothing expected");
                errors++;
            end
            else
            begin
                want = predicted_bus.pop_front();
                check_field("scl_out", want.scl_out, rsp_item.scl_out);
                check_field("sda_out", want.sda_out, rsp_item.sda_out);
                check_field("rx_valid", want.rx_valid, rsp_item.rx_valid);
                check_field("rx_byte", want.rx_byte, rsp_item.rx_byte);
                check_field("rx_last", want.rx_last, rsp_item.rx_last);
                check_field("nack_seen", want.nack_seen, rsp_item.nack_seen);
                check_field("busy_res", want.busy_res, rsp_item.busy_res);
                check_field("done_res", want.done_res, rsp_item.done_res);
            end
            if (rsp_item.rx_valid === 1'b1)
                n_rx_bytes++;
            if (rsp_item.done_res === 1'b1)
                n_stops++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet <= 0;
        else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                 || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        req_t t;
        dev_addr = DEVICE_ADDRESS_RESET;
        pticks = PHASE_TICKS_RESET;
        ph = PH_IDLE;
        bidx = '0;
        shreg = '0;
        bytes_due = '0;
        tcount = '0;
        saved = '0;

        // idle ticks, unknown command, then transactions at the field extremes
        plan[0]  = mk_row(CMD_NONE, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, SDA_ACK, 1'b1, IDLE_BUS);
        plan[1]  = mk_row(CMD_UNKNOWN, 8'hFF, 8'hFF, 7'h7F, 1'b1, 1'b0, SDA_ACK, 1'b1,
                          IDLE_BUS);
        plan[2]  = mk_row(CMD_NONE, 8'hFF, 8'hFF, 7'h7F, 1'b1, 1'b0, SDA_ACK, 1'b1, IDLE_BUS);
        plan[3]  = mk_row(CMD_WRITE, 8'h00, 8'h00, 7'd1, 1'b0, 1'b1, SDA_ACK, 1'b1, BUSY_BUS);
        plan[4]  = mk_row(CMD_WRITE, 8'hFF, 8'hFF, 7'd1, 1'b1, 1'b1, SDA_NACK, 1'b1, BUSY_BUS);
        plan[5]  = mk_row(CMD_WRITE, 8'hA5, 8'h5A, 7'd0, 1'b0, 1'b1, SDA_RANDOM, 1'b1,
                          BUSY_BUS);
        plan[6]  = mk_row(CMD_READ, 8'h00, 8'h00, 7'd0, 1'b0, 1'b1, SDA_NACK, 1'b1, BUSY_BUS);
        plan[7]  = mk_row(CMD_READ, 8'hFF, 8'h00, 7'd1, 1'b1, 1'b1, SDA_ACK, 1'b1, BUSY_BUS);
        plan[8]  = mk_row(CMD_READ, 8'h3C, 8'hC3, 7'd2, 1'b0, 1'b1, SDA_RANDOM, 1'b0,
                          IDLE_BUS);
        plan[9]  = mk_row(CMD_UNKNOWN, 8'h81, 8'h00, 7'd64, 1'b0, 1'b0, SDA_RANDOM, 1'b1,
                          IDLE_BUS);
        plan[10] = mk_row(CMD_NONE, 8'h7E, 8'h00, 7'd65, 1'b0, 1'b0, SDA_RANDOM, 1'b1,
                          IDLE_BUS);
        plan[11] = mk_row(CMD_READ, 8'h18, 8'hFF, 7'h7F, 1'b1, 1'b1, SDA_ACK, 1'b0, IDLE_BUS);
        plan[12] = mk_row(CMD_WRITE, 8'hFF, 8'h00, 7'd0, 1'b1, 1'b1, SDA_RANDOM, 1'b0,
                          IDLE_BUS);
        plan[13] = mk_row(CMD_READ, 8'h42, 8'h24, 7'd3, 1'b1, 1'b1, SDA_RANDOM, 1'b0,
                          IDLE_BUS);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_tick(plan[i].item, plan[i].typed, plan[i].want);
            if (plan[i].run_out)
                run_out(plan[i].mode);
        end
        run_random(RUN_BUDGET);

        apply_setting(7'd0, 16'd0);
        run_random(RUN_BUDGET);

        steady = 1'b1;
        apply_setting(7'd127, 16'd2);
        run_random(RUN_BUDGET);
        steady = 1'b0;

        apply_setting(7'h55, 16'd3);
        run_random(RUN_BUDGET);

        apply_setting(7'($urandom_range(127)), 16'($urandom_range(4, 1)));
        run_random(RUN_BUDGET);

        // longest phase: start a read and hold inside its first phase
        apply_setting(7'($urandom_range(127)), 16'hFFFF);
        t = random_tick(SDA_RANDOM);
        t.cmd = CMD_READ;
        send_tick(t, 1'b0, IDLE_BUS);
        repeat (LONG_RUN)
            send_tick(random_tick(SDA_RANDOM), 1'b0, IDLE_BUS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d tick items: %0d reads, %0d writes, %0d bytes received, %0d stops,",
                 n_ticks, n_reads, n_writes, n_rx_bytes, n_stops);
        $display("across %0d register settings from zero up to 65535 ticks per phase.",
                 n_settings + 1);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
